### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, clocked on clock and held off
// during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/bmppal_pkg.sv
// ----------------------------------------------------------------------------
// bmppal_pkg
// Types, widths, colour constants and register indexes of the bitmap
// palette packer.
// ----------------------------------------------------------------------------
package bmppal_pkg;

   localparam int BYTE_W = 8;
   localparam int COLOR_W = 24;
   localparam int CFG_W = 11;
   localparam int CODE_W = 4;
   localparam int ADDR_W = 19;

   localparam int DEF_MAX_WIDTH = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;
   localparam int DEF_HEADER_BYTES = 54;

   localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH = CFG_W'(480);
   localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = CFG_W'(800);

   localparam logic [COLOR_W-1:0] COLOR_BLACK = 24'h000000;
   localparam logic [COLOR_W-1:0] COLOR_YELLOW = 24'he6e600;
   localparam logic [COLOR_W-1:0] COLOR_RED = 24'hcc0000;
   localparam logic [COLOR_W-1:0] COLOR_BLUE = 24'h0033cc;
   localparam logic [COLOR_W-1:0] COLOR_GREEN = 24'h00cc00;

   typedef enum logic [2:0] {
      REG_IMAGE_WIDTH = 3'd0,
      REG_IMAGE_HEIGHT = 3'd1,
      REG_CODE_BLACK = 3'd2,
      REG_CODE_WHITE = 3'd3,
      REG_CODE_YELLOW = 3'd4,
      REG_CODE_RED = 3'd5,
      REG_CODE_BLUE = 3'd6,
      REG_CODE_GREEN = 3'd7
   } reg_index_type;

   typedef enum logic [1:0] {
      PHASE_LOW = 2'd0,
      PHASE_MID = 2'd1,
      PHASE_HIGH = 2'd2
   } byte_phase_type;

   typedef struct packed {
      logic [CODE_W-1:0] black;
      logic [CODE_W-1:0] white;
      logic [CODE_W-1:0] yellow;
      logic [CODE_W-1:0] red;
      logic [CODE_W-1:0] blue;
      logic [CODE_W-1:0] green;
   } codes_type;

   localparam codes_type RST_CODES = '{
      black: CODE_W'(0), white: CODE_W'(1), yellow: CODE_W'(2),
      red: CODE_W'(3), blue: CODE_W'(5), green: CODE_W'(6)
   };

endpackage

### hdl/bmppal_map.sv
// ----------------------------------------------------------------------------
// bmppal_map
// Colour matcher: maps an exact 24-bit colour to its configured panel code,
// anything unmatched to the white code.
// ----------------------------------------------------------------------------
module bmppal_map
   import bmppal_pkg::*;
(
   input  logic [COLOR_W-1:0] color,
   input  codes_type          codes,
   output logic [CODE_W-1:0]  code
);

   always_comb begin
      unique case (color)
         COLOR_BLACK:  code = codes.black;
         COLOR_YELLOW: code = codes.yellow;
         COLOR_RED:    code = codes.red;
         COLOR_BLUE:   code = codes.blue;
         COLOR_GREEN:  code = codes.green;
         default:      code = codes.white;
      endcase
   end

endmodule

### hdl/bmp_palette_rotated_nibble_packer.sv
// ----------------------------------------------------------------------------
// bmp_palette_rotated_nibble_packer
// Turns a 24-bit bitmap byte stream into nibble writes for a 4bpp
// framebuffer rotated by 90 degrees.
// ----------------------------------------------------------------------------
// Takes one stream byte per clock cycle and keeps that rate indefinitely
// while the result side takes its transactions. A byte is held in an input
// register, and the result that it completes is loaded from there into the
// output register once that register is free. The first HEADER_BYTES bytes
// are dropped; every third byte after that completes a pixel and yields one
// write (address column*(image_height/2)+row/2, upper nibble on even rows).
// After the last pixel of the last row all bytes are dropped until reset.
// req_stall rises in the same cycle that a held result is stalled and the
// input register carries a pixel-completing byte. Change configuration only
// while no transaction is in flight.
module bmp_palette_rotated_nibble_packer
   import bmppal_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
   input  logic              clock,
   input  logic              reset,

   input  logic              csr_write,
   input  logic [2:0]        csr_index,
   input  logic [CFG_W-1:0]  csr_data,

   input  logic              req_valid,
   output logic              req_stall,
   input  logic [BYTE_W-1:0] req_stream_byte,

   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [ADDR_W-1:0] rsp_write_address,
   output logic [CODE_W-1:0] rsp_pixel_code,
   output logic              rsp_upper_nibble,
   output logic              rsp_last_pixel
);

   `include "assert_macros.svh"

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int HDR_W = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES + 1) : 1;
   localparam int CCMP_W = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
   localparam int RCMP_W = (ROW_W + 1 > CFG_W) ? ROW_W + 1 : CFG_W;

   // configuration
   logic [CFG_W-1:0]  width_ff, height_ff;
   codes_type         codes_ff;

   // input register
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;

   // stream state
   logic [HDR_W-1:0]  hdr_ff, hdr_in;
   byte_phase_type    phase_ff, phase_in;
   logic [15:0]       part_ff, part_in;
   logic [COL_W-1:0]  column_ff, column_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [ADDR_W-1:0] acc_ff, acc_in;
   logic              done_ff, done_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] rsp_addr_ff;
   logic [CODE_W-1:0] rsp_code_ff;
   logic              rsp_upper_ff;
   logic              rsp_last_ff;

   logic              pixel_byte;
   logic              out_free;
   logic              in_move;
   logic              out_load;
   logic              req_accept;
   logic [CCMP_W-1:0] col_inc;
   logic [RCMP_W-1:0] row_inc;
   logic              row_end, last_row;
   logic [ADDR_W-1:0] stride;
   logic [ADDR_W-1:0] pixel_addr;
   logic [CODE_W-1:0] pixel_code;
   logic              start_state;

   bmppal_map u_map (
      .color ({in_byte_ff, part_ff}),
      .codes (codes_ff),
      .code  (pixel_code)
   );

   // ---- handshake ----
   assign pixel_byte = !done_ff && (hdr_ff == '0) && (phase_ff == PHASE_HIGH);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign in_move    = in_valid_ff && (!pixel_byte || out_free);
   assign out_load   = in_move && pixel_byte;
   assign req_stall  = in_valid_ff && !in_move;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (in_move) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---- pixel position and address ----
   assign col_inc    = CCMP_W'(column_ff) + CCMP_W'(1);
   assign row_inc    = RCMP_W'(row_ff) + RCMP_W'(1);
   assign row_end    = (col_inc >= CCMP_W'(width_ff)) || (col_inc >= CCMP_W'(MAX_WIDTH));
   assign last_row   = (row_inc >= RCMP_W'(height_ff)) || (row_inc >= RCMP_W'(MAX_HEIGHT));
   assign stride     = ADDR_W'(height_ff >> 1);
   assign pixel_addr = acc_ff + ADDR_W'(row_ff >> 1);

   always_comb begin
      hdr_in    = hdr_ff;
      phase_in  = phase_ff;
      part_in   = part_ff;
      column_in = column_ff;
      row_in    = row_ff;
      acc_in    = acc_ff;
      done_in   = done_ff;
      if (in_move && !done_ff) begin
         if (hdr_ff != '0) begin
            hdr_in = hdr_ff - HDR_W'(1);
         end else begin
            unique case (phase_ff)
               PHASE_LOW: begin
                  part_in[7:0] = in_byte_ff;
                  phase_in     = PHASE_MID;
               end
               PHASE_MID: begin
                  part_in[15:8] = in_byte_ff;
                  phase_in      = PHASE_HIGH;
               end
               PHASE_HIGH: begin
                  phase_in = PHASE_LOW;
                  if (row_end) begin
                     column_in = '0;
                     acc_in    = '0;
                     if (last_row) begin
                        done_in = 1'b1;
                     end else begin
                        row_in = row_inc[ROW_W-1:0];
                     end
                  end else begin
                     column_in = col_inc[COL_W-1:0];
                     acc_in    = acc_ff + stride;
                  end
               end
               default: begin
                  phase_in = PHASE_LOW;
               end
            endcase
         end
      end
   end

   // ---- registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RST_IMAGE_WIDTH;
         height_ff <= RST_IMAGE_HEIGHT;
         codes_ff  <= RST_CODES;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:  width_ff        <= csr_data;
            REG_IMAGE_HEIGHT: height_ff       <= csr_data;
            REG_CODE_BLACK:   codes_ff.black  <= csr_data[CODE_W-1:0];
            REG_CODE_WHITE:   codes_ff.white  <= csr_data[CODE_W-1:0];
            REG_CODE_YELLOW:  codes_ff.yellow <= csr_data[CODE_W-1:0];
            REG_CODE_RED:     codes_ff.red    <= csr_data[CODE_W-1:0];
            REG_CODE_BLUE:    codes_ff.blue   <= csr_data[CODE_W-1:0];
            REG_CODE_GREEN:   codes_ff.green  <= csr_data[CODE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         hdr_ff       <= HDR_W'(HEADER_BYTES);
         phase_ff     <= PHASE_LOW;
         part_ff      <= '0;
         column_ff    <= '0;
         row_ff       <= '0;
         acc_ff       <= '0;
         done_ff      <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         hdr_ff       <= hdr_in;
         phase_ff     <= phase_in;
         part_ff      <= part_in;
         column_ff    <= column_in;
         row_ff       <= row_in;
         acc_ff       <= acc_in;
         done_ff      <= done_in;
      end
   end

   // payload: hold while stalled
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_stream_byte;
      end
      if (out_load) begin
         rsp_addr_ff  <= pixel_addr;
         rsp_code_ff  <= pixel_code;
         rsp_upper_ff <= !row_ff[0];
         rsp_last_ff  <= row_end && last_row;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_write_address = rsp_addr_ff;
   assign rsp_pixel_code    = rsp_code_ff;
   assign rsp_upper_nibble  = rsp_upper_ff;
   assign rsp_last_pixel    = rsp_last_ff;

   // ---- assertions ----
   assign start_state = (phase_ff == PHASE_LOW) && (column_ff == '0) && (row_ff == '0);

   `ASSERT_NEXT(a_done_quiet, done_ff, done_ff && !out_load, "write after end of image")
   `ASSERT_IMPLIES(a_last_done, rsp_valid_ff && rsp_last_ff, done_ff, "last pixel, not done")
   `ASSERT_IMPLIES(a_header_idle, hdr_ff != '0, start_state, "pixel state moved in header")
   `ASSERT_IMPLIES(a_acc_col0, column_ff == '0, acc_ff == '0, "accumulator set at column 0")

endmodule
